// File: rtl/static_linked_list_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Static linked list engine: assertion macros
// Clocked implication shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define SLLE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slle port check failed");

// next-cycle implication
`define SLLE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slle port check failed");

`endif

// File: rtl/slle_pkg.sv
// ----------------------------------------------------------------------------
// Static linked list engine: package
// Request and result types, command codes and controller/datapath links.
// ----------------------------------------------------------------------------
package slle_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    K_CLEAR  = 3'd0,
    K_APPEND = 3'd1,
    K_INSERT = 3'd2,
    K_DELETE = 3'd3,
    K_LOCATE = 3'd4,
    K_GET    = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WS_COUNT,
    WS_POS_M1,
    WS_POS,
    WS_ONE
  } walk_sel_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_WRD,
    S_WEVAL,
    S_LINK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [POS_W-1:0]         found_position;
    logic signed [DATA_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic      latch_in;
    logic      init_head;
    logic      clear_all;
    logic      start_walk;
    walk_sel_t walk_sel;
    logic      step;
    logic      alloc_write;
    logic      link_new;
    logic      unlink;
    logic      res_set;
    status_t   res_code;
    logic      res_take_val;
    logic      res_take_found;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pos_bad_rd;
    logic              pos_bad_ins;
    logic              full;
    logic              empty;
    logic              rem_zero;
    logic              hit;
    logic              last;
    logic              out_free;
  } dp_stat_t;

endpackage

// File: rtl/slle_ram.sv
// ----------------------------------------------------------------------------
// Static linked list engine: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/slle_ctrl.sv
// ----------------------------------------------------------------------------
// Static linked list engine: controller
// Decodes each request, sequences the chain walk and the link updates.
// ----------------------------------------------------------------------------
module slle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  slle_pkg::dp_stat_t  stat,
  output slle_pkg::ctrl_cmd_t cmd
);

  slle_pkg::state_t state_r;
  slle_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slle_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != slle_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      slle_pkg::S_INIT: begin
        cmd.init_head = 1'b1;
        cmd.clear_all = 1'b1;
        state_nxt     = slle_pkg::S_IDLE;
      end
      slle_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = slle_pkg::S_DECODE;
        end
      end
      slle_pkg::S_DECODE: begin
        state_nxt   = slle_pkg::S_RESP;
        cmd.res_set = 1'b1;
        unique case (stat.kind)
          slle_pkg::K_CLEAR: begin
            cmd.init_head = 1'b1;
            cmd.clear_all = 1'b1;
            cmd.res_code  = slle_pkg::ST_OK;
          end
          slle_pkg::K_APPEND: begin
            if (stat.full) begin
              cmd.res_code = slle_pkg::ST_FULL;
            end else begin
              cmd.res_set    = 1'b0;
              cmd.start_walk = 1'b1;
              cmd.walk_sel   = slle_pkg::WS_COUNT;
              state_nxt      = slle_pkg::S_WRD;
            end
          end
          slle_pkg::K_INSERT: begin
            if (stat.pos_bad_ins) begin
              cmd.res_code = slle_pkg::ST_BADPOS;
            end else if (stat.full) begin
              cmd.res_code = slle_pkg::ST_FULL;
            end else begin
              cmd.res_set    = 1'b0;
              cmd.start_walk = 1'b1;
              cmd.walk_sel   = slle_pkg::WS_POS_M1;
              state_nxt      = slle_pkg::S_WRD;
            end
          end
          slle_pkg::K_DELETE, slle_pkg::K_GET: begin
            if (stat.pos_bad_rd) begin
              cmd.res_code = slle_pkg::ST_BADPOS;
            end else begin
              cmd.res_set    = 1'b0;
              cmd.start_walk = 1'b1;
              cmd.walk_sel   = slle_pkg::WS_POS;
              state_nxt      = slle_pkg::S_WRD;
            end
          end
          slle_pkg::K_LOCATE: begin
            if (stat.empty) begin
              cmd.res_code = slle_pkg::ST_NOTFOUND;
            end else begin
              cmd.res_set    = 1'b0;
              cmd.start_walk = 1'b1;
              cmd.walk_sel   = slle_pkg::WS_ONE;
              state_nxt      = slle_pkg::S_WRD;
            end
          end
          default: begin
            cmd.res_code = slle_pkg::ST_BADPOS;
          end
        endcase
      end
      slle_pkg::S_WRD: begin
        state_nxt = slle_pkg::S_WEVAL;
      end
      slle_pkg::S_WEVAL: begin
        if (!stat.rem_zero) begin
          cmd.step  = 1'b1;
          state_nxt = slle_pkg::S_WRD;
        end else begin
          state_nxt = slle_pkg::S_RESP;
          unique case (stat.kind)
            slle_pkg::K_APPEND, slle_pkg::K_INSERT: begin
              cmd.alloc_write = 1'b1;
              state_nxt       = slle_pkg::S_LINK;
            end
            slle_pkg::K_DELETE: begin
              cmd.unlink       = 1'b1;
              cmd.res_set      = 1'b1;
              cmd.res_code     = slle_pkg::ST_OK;
              cmd.res_take_val = 1'b1;
            end
            slle_pkg::K_GET: begin
              cmd.res_set      = 1'b1;
              cmd.res_code     = slle_pkg::ST_OK;
              cmd.res_take_val = 1'b1;
            end
            slle_pkg::K_LOCATE: begin
              if (stat.hit) begin
                cmd.res_set        = 1'b1;
                cmd.res_code       = slle_pkg::ST_OK;
                cmd.res_take_found = 1'b1;
              end else if (stat.last) begin
                cmd.res_set  = 1'b1;
                cmd.res_code = slle_pkg::ST_NOTFOUND;
              end else begin
                cmd.step  = 1'b1;
                state_nxt = slle_pkg::S_WRD;
              end
            end
            default: begin
              cmd.res_set  = 1'b1;
              cmd.res_code = slle_pkg::ST_BADPOS;
            end
          endcase
        end
      end
      slle_pkg::S_LINK: begin
        cmd.link_new = 1'b1;
        cmd.res_set  = 1'b1;
        cmd.res_code = slle_pkg::ST_OK;
        state_nxt    = slle_pkg::S_RESP;
      end
      slle_pkg::S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = slle_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = slle_pkg::S_INIT;
      end
    endcase
  end

endmodule

// File: rtl/slle_dp.sv
// ----------------------------------------------------------------------------
// Static linked list engine: datapath
// Link and value RAMs, free-slot stack, walk cursor, counters, result register.
// ----------------------------------------------------------------------------
module slle_dp #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slle_pkg::in_item_t  in_data,
  input  logic                out_stall,
  input  slle_pkg::ctrl_cmd_t cmd,
  output slle_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output slle_pkg::out_item_t out_data
);

  localparam int unsigned SW   = $clog2(SLOT_COUNT);
  localparam int unsigned CMPW = ((SW > slle_pkg::POS_W) ? SW : slle_pkg::POS_W) + 1;

  slle_pkg::in_item_t  cmd_r,      cmd_nxt;
  slle_pkg::out_item_t res_r,      res_nxt;
  slle_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SW-1:0]       count_r,    count_nxt;
  logic [SW-1:0]       cur_r,      cur_nxt;
  logic [SW-1:0]       prev_r,     prev_nxt;
  logic [SW-1:0]       new_r,      new_nxt;
  logic [SW-1:0]       idx_r,      idx_nxt;
  logic [SW-1:0]       sp_r,       sp_nxt;
  logic [SW:0]         hw_r,       hw_nxt;
  logic [CMPW-1:0]     rem_r,      rem_nxt;

  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     cnt_ext;
  logic [CMPW-1:0]     idx_ext;
  logic [CMPW-1:0]     walk_steps;
  logic [SW-1:0]       alloc_slot;

  logic                        link_we;
  logic [SW-1:0]               link_waddr;
  logic [SW-1:0]               link_wdata;
  logic [SW-1:0]               link_q;
  logic [slle_pkg::DATA_W-1:0] val_q;
  logic [SW-1:0]               fs_q;

  slle_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (cur_r),
    .rdata (link_q)
  );

  slle_ram #(.WIDTH(slle_pkg::DATA_W), .DEPTH(SLOT_COUNT)) u_value_ram (
    .clk   (clk),
    .we    (cmd.alloc_write),
    .waddr (alloc_slot),
    .wdata (cmd_r.value),
    .raddr (cur_r),
    .rdata (val_q)
  );

  slle_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_free_ram (
    .clk   (clk),
    .we    (cmd.unlink),
    .waddr (sp_r),
    .wdata (cur_r),
    .raddr (sp_r - SW'(1)),
    .rdata (fs_q)
  );

  assign pos_ext    = CMPW'(cmd_r.position);
  assign cnt_ext    = CMPW'(count_r);
  assign idx_ext    = CMPW'(idx_r);
  assign alloc_slot = (sp_r != '0) ? fs_q : hw_r[SW-1:0];

  always_comb begin
    unique case (cmd.walk_sel)
      slle_pkg::WS_COUNT:  walk_steps = cnt_ext;
      slle_pkg::WS_POS_M1: walk_steps = pos_ext - CMPW'(1);
      slle_pkg::WS_POS:    walk_steps = pos_ext;
      slle_pkg::WS_ONE:    walk_steps = CMPW'(1);
      default:             walk_steps = '0;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_r;
    link_wdata = link_q;
    priority if (cmd.init_head) begin
      link_we    = 1'b1;
      link_waddr = '0;
      link_wdata = '0;
    end else if (cmd.alloc_write) begin
      link_we    = 1'b1;
      link_waddr = alloc_slot;
      link_wdata = link_q;
    end else if (cmd.link_new) begin
      link_we    = 1'b1;
      link_waddr = cur_r;
      link_wdata = new_r;
    end else if (cmd.unlink) begin
      link_we    = 1'b1;
      link_waddr = prev_r;
      link_wdata = link_q;
    end
  end

  always_comb begin
    stat.kind        = cmd_r.kind;
    stat.pos_bad_rd  = (pos_ext == '0) || (pos_ext > cnt_ext);
    stat.pos_bad_ins = (pos_ext == '0) || (pos_ext > (cnt_ext + CMPW'(1)));
    stat.full        = (count_r == SW'(SLOT_COUNT - 1));
    stat.empty       = (count_r == '0);
    stat.rem_zero    = (rem_r == '0);
    stat.hit         = (val_q == cmd_r.value);
    stat.last        = (idx_r == count_r) || (link_q == '0);
    stat.out_free    = !out_valid_r || !out_stall;
  end

  always_comb begin
    cmd_nxt       = cmd.latch_in ? in_data : cmd_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    new_nxt       = new_r;
    idx_nxt       = idx_r;
    sp_nxt        = sp_r;
    hw_nxt        = hw_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.clear_all) begin
      count_nxt = '0;
      sp_nxt    = '0;
      hw_nxt    = (SW+1)'(1);
    end
    if (cmd.start_walk) begin
      cur_nxt  = '0;
      prev_nxt = '0;
      idx_nxt  = '0;
      rem_nxt  = walk_steps;
    end
    if (cmd.step) begin
      prev_nxt = cur_r;
      cur_nxt  = link_q;
      idx_nxt  = idx_r + SW'(1);
      rem_nxt  = (rem_r == '0) ? rem_r : rem_r - CMPW'(1);
    end
    if (cmd.alloc_write) begin
      new_nxt = alloc_slot;
      if (sp_r != '0) begin
        sp_nxt = sp_r - SW'(1);
      end else begin
        hw_nxt = hw_r + (SW+1)'(1);
      end
    end
    if (cmd.link_new) begin
      count_nxt = count_r + SW'(1);
    end
    if (cmd.unlink) begin
      sp_nxt    = sp_r + SW'(1);
      count_nxt = count_r - SW'(1);
    end
    if (cmd.res_set) begin
      res_nxt.status         = cmd.res_code;
      res_nxt.read_value     = cmd.res_take_val ? val_q : '0;
      res_nxt.found_position = cmd.res_take_found ? idx_ext[slle_pkg::POS_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sp_r        <= '0;
      hw_r        <= (SW+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    new_r      <= new_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/static_linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// Static linked list engine: top level
// Cursor-array singly linked list with clear, append, insert, delete,
// locate and get requests, one result per request.
//
//   channel | ports                            | direction
//   in      | in_valid, in_stall, in_data      | request in
//   out     | out_valid, out_stall, out_data   | result out
//
// The walk for a request is k link hops: none for a clear or a rejected request,
// the most for a delete at the tail of a full list or a failed locate over one.
// Each hop is one registered read of the link RAM followed by an evaluate state.
// After reset the init state clears the header link before the first request.
// A stalled result holds in the output register; the next request is taken
// meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module static_linked_list_engine_top #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  slle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slle_pkg::out_item_t out_data
);

  slle_pkg::ctrl_cmd_t cmd;
  slle_pkg::dp_stat_t  stat;

  slle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  slle_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: rtl/slle_chk.sv
// ----------------------------------------------------------------------------
// Static linked list engine: port checker
// Port-level checks on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "static_linked_list_engine_top_defines.svh"

module slle_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input slle_pkg::out_item_t out_data
);

  `SLLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SLLE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `SLLE_ASSERT_IMP(a_found_ok, out_valid && (out_data.found_position != '0), out_data.status == slle_pkg::ST_OK)
  `SLLE_ASSERT_IMP(a_err_clean, out_valid && (out_data.status != slle_pkg::ST_OK), (out_data.read_value == '0) && (out_data.found_position == '0))

endmodule

bind static_linked_list_engine_top slle_chk u_slle_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: bench/tb_static_linked_list_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Static linked list engine: testbench
// Drives clear, append, insert, delete, locate and get requests, plus the
// unused kind codes, into the engine. A mirror of the slot array, the link
// table and the element count predicts each result. Every result must match
// the oldest pending prediction field by field. The requests go in phases with
// no idling, sender gaps, receiver stalls, and both at once.
// ----------------------------------------------------------------------------
module tb_static_linked_list_engine_top;
  import slle_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int unsigned RANDOM_PER_PHASE = 270;
  localparam logic [KIND_W-1:0] KIND_RESERVED_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RESERVED_7 = 3'd7;
  localparam int unsigned MODE_GROW = 0;
  localparam int unsigned MODE_SHRINK = 1;
  localparam int unsigned MODE_CHURN = 2;

  class list_mirror;
    logic [POS_W-1:0]  link_of[SLOTS];
    bit                slot_busy[SLOTS];
    logic [DATA_W-1:0] slot_data[SLOTS];
    int unsigned       element_count;
    out_item_t         expected_results[$];
    int unsigned       error_count;

    function new();
      clear_list();
      error_count = 0;
    endfunction

    function void clear_list();
      foreach (link_of[i]) begin
        link_of[i] = '0;
        slot_busy[i] = 1'b0;
        slot_data[i] = '0;
      end
      element_count = 0;
    endfunction

    function int unsigned slot_before(int unsigned pos);
      int unsigned s;
      s = 0;
      for (int unsigned i = 1; i < pos; i++) s = link_of[s];
      return s;
    endfunction

    function status_t place_after(int unsigned prev, logic [DATA_W-1:0] v);
      int unsigned f;
      f = 0;
      for (int unsigned i = SLOTS - 1; i >= 1; i--) begin
        if (!slot_busy[i]) f = i;
      end
      if (f == 0) return ST_FULL;
      slot_busy[f] = 1'b1;
      slot_data[f] = v;
      link_of[f] = link_of[prev];
      link_of[prev] = POS_W'(f);
      element_count++;
      return ST_OK;
    endfunction

    function out_item_t apply_command(in_item_t req);
      out_item_t   res;
      int unsigned pos;
      int unsigned prev;
      int unsigned cur;
      res = '0;
      res.status = ST_OK;
      pos = req.position;
      case (req.kind)
        K_CLEAR: clear_list();
        K_APPEND: begin
          if (element_count >= SLOTS - 1) res.status = ST_FULL;
          else res.status = place_after(slot_before(element_count + 1), req.value);
        end
        K_INSERT: begin
          if (pos < 1 || pos > element_count + 1) res.status = ST_BADPOS;
          else if (element_count >= SLOTS - 1) res.status = ST_FULL;
          else res.status = place_after(slot_before(pos), req.value);
        end
        K_DELETE: begin
          if (pos < 1 || pos > element_count) begin
            res.status = ST_BADPOS;
          end else begin
            prev = slot_before(pos);
            cur = link_of[prev];
            res.read_value = slot_data[cur];
            link_of[prev] = link_of[cur];
            link_of[cur] = '0;
            slot_busy[cur] = 1'b0;
            element_count--;
          end
        end
        K_LOCATE: begin
          res.status = ST_NOTFOUND;
          cur = link_of[0];
          for (int unsigned i = 1; i <= element_count && cur != 0; i++) begin
            if (slot_data[cur] == req.value) begin
              res.status = ST_OK;
              res.found_position = POS_W'(i);
              break;
            end
            cur = link_of[cur];
          end
        end
        K_GET: begin
          if (pos < 1 || pos > element_count) res.status = ST_BADPOS;
          else res.read_value = slot_data[link_of[slot_before(pos)]];
        end
        default: res.status = ST_BADPOS;
      endcase
      return res;
    endfunction

    function void note_request(in_item_t req);
      expected_results.push_back(apply_command(req));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no pending request: status %0d found %0d value %0d",
                 $time, got.status, got.found_position, got.read_value);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        error_count++;
      end
      if (got.found_position !== want.found_position) begin
        $display("%0t: found_position mismatch: expected %0d actual %0d",
                 $time, want.found_position, got.found_position);
        error_count++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch: expected %0d actual %0d",
                 $time, want.read_value, got.read_value);
        error_count++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  list_mirror        mirror = new();
  int unsigned       sender_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       quiet_cycles = 0;
  logic [DATA_W-1:0] value_pool[8];

  static_linked_list_engine_top #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) mirror.check_result(out_data);
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_static_linked_list_engine_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_item_t build_request(logic [KIND_W-1:0] kind,
                                             logic [POS_W-1:0] pos,
                                             logic [DATA_W-1:0] value);
    in_item_t req;
    req.kind = kind;
    req.position = pos;
    req.value = value;
    return req;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
    return DATA_W'($urandom);
  endfunction

  function automatic in_item_t random_request(int unsigned mode, int unsigned count);
    in_item_t    req;
    int unsigned r;
    int unsigned cut_app;
    int unsigned cut_ins;
    int unsigned cut_del;
    int unsigned cut_loc;
    int unsigned cut_get;
    case (mode)
      MODE_GROW: begin
        cut_app = 45; cut_ins = 70; cut_del = 75; cut_loc = 85; cut_get = 95;
      end
      MODE_SHRINK: begin
        cut_app = 10; cut_ins = 15; cut_del = 65; cut_loc = 80; cut_get = 95;
      end
      default: begin
        cut_app = 20; cut_ins = 40; cut_del = 60; cut_loc = 75; cut_get = 90;
      end
    endcase
    req.value = pick_value();
    req.position = POS_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < cut_app) begin
      req.kind = K_APPEND;
    end else if (r < cut_ins) begin
      req.kind = K_INSERT;
      req.position = POS_W'($urandom_range(1, count + 1));
    end else if (r < cut_del) begin
      req.kind = K_DELETE;
      req.position = POS_W'($urandom_range(1, count));
    end else if (r < cut_loc) begin
      req.kind = K_LOCATE;
    end else if (r < cut_get) begin
      req.kind = K_GET;
      req.position = POS_W'($urandom_range(1, count));
    end else begin
      req.kind = KIND_W'($urandom_range(0, 7));
    end
    return req;
  endfunction

  task automatic send_request(in_item_t req);
    int unsigned gap;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_request(req);
  endtask

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    value_pool[0] = 16'h8000;
    value_pool[1] = 16'h7fff;
    value_pool[2] = 16'h0000;
    value_pool[3] = 16'hffff;
    for (int i = 4; i < 8; i++) value_pool[i] = DATA_W'($urandom);
    mode = MODE_GROW;
    mode_left = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_request(build_request(K_CLEAR, 4'd0, 16'h0000));
    send_request(build_request(K_GET, 4'd1, 16'h0000));
    send_request(build_request(K_DELETE, 4'd1, 16'h0000));
    send_request(build_request(K_LOCATE, 4'd0, 16'h0005));
    send_request(build_request(K_INSERT, 4'd0, 16'h0011));
    send_request(build_request(K_INSERT, 4'd2, 16'h0022));
    send_request(build_request(K_INSERT, 4'd1, 16'h8000));
    send_request(build_request(K_APPEND, 4'd15, 16'h7fff));
    send_request(build_request(K_APPEND, 4'd0, 16'h0000));
    send_request(build_request(K_INSERT, 4'd4, 16'hffff));
    send_request(build_request(K_INSERT, 4'd2, 16'h1234));
    send_request(build_request(K_LOCATE, 4'd0, 16'hffff));
    send_request(build_request(K_LOCATE, 4'd15, 16'h0000));
    send_request(build_request(K_LOCATE, 4'd0, 16'h0007));
    send_request(build_request(K_GET, 4'd0, 16'h0000));
    send_request(build_request(K_GET, 4'd5, 16'hffff));
    send_request(build_request(K_GET, 4'd6, 16'h0000));
    send_request(build_request(K_DELETE, 4'd5, 16'h0000));
    send_request(build_request(K_DELETE, 4'd1, 16'h0000));
    send_request(build_request(KIND_RESERVED_6, 4'd1, 16'h0001));
    send_request(build_request(KIND_RESERVED_7, 4'd15, 16'hffff));
    send_request(build_request(K_INSERT, 4'd15, 16'h5a5a));
    send_request(build_request(K_CLEAR, 4'd15, 16'hffff));
    send_request(build_request(K_GET, 4'd1, 16'h0000));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
        1: begin sender_idle_pct = 62; recv_stall_pct = 0; end
        2: begin sender_idle_pct = 0; recv_stall_pct = 62; end
        default: begin sender_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (mode_left == 0) begin
          mode = $urandom_range(MODE_GROW, MODE_CHURN);
          mode_left = $urandom_range(10, 40);
        end
        mode_left--;
        send_request(random_request(mode, mirror.element_count));
      end
    end
    in_valid <= 1'b0;

    while (mirror.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.error_count == 0) begin
      $display("tb_static_linked_list_engine_top OK");
    end else begin
      $display("tb_static_linked_list_engine_top NOT OK");
    end
    $finish;
  end

endmodule
